### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the tachometer modules; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

### src/ftrpm_pkg.sv
// ----------------------------------------------------------------------------
// ftrpm_pkg
// Widths, codes and control types of the fan tachometer rpm meter.
// ----------------------------------------------------------------------------
`default_nettype none

package ftrpm_pkg;

    localparam int AVG_DEPTH    = 4;
    localparam int NUM_CHANNELS = 2;

    localparam int RPM_W     = 26;
    localparam int STAMP_W   = 32;
    localparam int OVF_W     = 16;
    localparam int CAP_W     = 16;
    localparam int TIME_W    = 32;
    localparam int TIMEOUT_W = 16;
    localparam int ACT_W     = 2;
    localparam int CH_W      = 1;

    localparam int FILL_W = $clog2(AVG_DEPTH + 1);
    localparam int SLOT_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int SUM_W  = RPM_W + FILL_W;
    localparam int DIV_W  = SUM_W;
    localparam int DIVS_W = STAMP_W;
    localparam int CNT_W  = $clog2(DIV_W + 1);

    localparam int CH_SECOND = (NUM_CHANNELS > 1) ? 1 : 0;

    localparam int IN_TDATA_W  = 48;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 56;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 26;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET   = 16'd1000;
    localparam logic [RPM_W-1:0]     NUMERATOR_RESET = 26'd30000000;

    localparam logic [CFG_IDX_W-1:0] CFG_STOP_TIMEOUT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RPM_NUMERATOR = 2'd1;

    typedef enum logic [ACT_W-1:0] {
        ACT_OVERFLOW = 2'd0,
        ACT_CAPTURE  = 2'd1,
        ACT_SERVICE  = 2'd2,
        ACT_NOP      = 2'd3
    } action_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic div_start;
        logic div_sel_avg;
        logic push;
        logic sum_step;
        logic avg_write;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic is_capture;
        logic div_done;
        logic sum_last;
    } sts_t;

endpackage

`default_nettype wire

### src/ftrpm_dp.sv
// ----------------------------------------------------------------------------
// ftrpm_dp
// Datapath: timestamps, shared radix-2 divider, rpm history, averages.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ftrpm_dp (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire ftrpm_pkg::cmd_t                       cmd,
    output ftrpm_pkg::sts_t                            sts,
    input  wire logic [ftrpm_pkg::ACT_W-1:0]           action,
    input  wire logic [ftrpm_pkg::CH_W-1:0]            channel,
    input  wire logic [ftrpm_pkg::CAP_W-1:0]           capture_value,
    input  wire logic [ftrpm_pkg::TIME_W-1:0]          now_ms,
    input  wire logic                                  cfg_valid,
    input  wire logic [ftrpm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [ftrpm_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic      [ftrpm_pkg::RPM_W-1:0]           rpm_first,
    output logic      [ftrpm_pkg::RPM_W-1:0]           rpm_second
);

    // configuration
    logic [ftrpm_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic [ftrpm_pkg::RPM_W-1:0]     numer_reg;

    // latched word
    ftrpm_pkg::action_t               act_reg;
    logic [ftrpm_pkg::CH_W-1:0]       ch_reg;
    logic [ftrpm_pkg::CAP_W-1:0]      cap_reg;
    logic [ftrpm_pkg::TIME_W-1:0]     now_reg;

    // tachometer state
    logic [ftrpm_pkg::OVF_W-1:0]   ovf_reg;
    logic [ftrpm_pkg::STAMP_W-1:0] last_stamp_reg [ftrpm_pkg::NUM_CHANNELS];
    logic [ftrpm_pkg::TIME_W-1:0]  last_pulse_reg [ftrpm_pkg::NUM_CHANNELS];
    logic [ftrpm_pkg::RPM_W-1:0]
        hist_reg [ftrpm_pkg::NUM_CHANNELS][ftrpm_pkg::AVG_DEPTH];
    logic [ftrpm_pkg::FILL_W-1:0]  fill_reg [ftrpm_pkg::NUM_CHANNELS];
    logic [ftrpm_pkg::SLOT_W-1:0]  slot_reg [ftrpm_pkg::NUM_CHANNELS];
    logic [ftrpm_pkg::RPM_W-1:0]   avg_reg  [ftrpm_pkg::NUM_CHANNELS];

    // averaging accumulator
    logic [ftrpm_pkg::SUM_W-1:0]  acc_reg;
    logic [ftrpm_pkg::SLOT_W-1:0] k_reg;

    // divider
    logic [ftrpm_pkg::DIV_W-1:0]  dvd_reg;
    logic [ftrpm_pkg::DIVS_W-1:0] dvs_reg;
    logic [ftrpm_pkg::DIVS_W-1:0] rem_reg;
    logic [ftrpm_pkg::CNT_W-1:0]  cnt_reg;

    // output word
    logic [ftrpm_pkg::RPM_W-1:0] out_first_reg;
    logic [ftrpm_pkg::RPM_W-1:0] out_second_reg;

    logic                            ch_present;
    logic [ftrpm_pkg::STAMP_W-1:0]   stamp;
    logic [ftrpm_pkg::STAMP_W-1:0]   diff;
    logic [ftrpm_pkg::DIVS_W:0]      trial;
    logic                            trial_ge;
    logic [ftrpm_pkg::DIVS_W-1:0]    rem_next;
    logic [ftrpm_pkg::DIV_W-1:0]     dvd_next;
    logic [ftrpm_pkg::RPM_W-1:0]     rpm_new;

    assign ch_present = (32'(ch_reg) < ftrpm_pkg::NUM_CHANNELS);
    assign stamp      = {ovf_reg, cap_reg};
    assign diff       = stamp - last_stamp_reg[ch_reg];

    // one quotient bit per cycle
    assign trial    = {rem_reg, dvd_reg[ftrpm_pkg::DIV_W-1]};
    assign trial_ge = (trial >= {1'b0, dvs_reg});
    assign rem_next = trial_ge ? ftrpm_pkg::DIVS_W'(trial - {1'b0, dvs_reg})
                               : trial[ftrpm_pkg::DIVS_W-1:0];
    assign dvd_next = {dvd_reg[ftrpm_pkg::DIV_W-2:0], trial_ge};

    // a zero period reads as zero rpm
    assign rpm_new = (dvs_reg == '0) ? '0 : dvd_reg[ftrpm_pkg::RPM_W-1:0];

    assign sts.is_capture = (act_reg == ftrpm_pkg::ACT_CAPTURE) && ch_present;
    assign sts.div_done   = (cnt_reg == ftrpm_pkg::CNT_W'(1));
    assign sts.sum_last   = (k_reg == ftrpm_pkg::SLOT_W'(ftrpm_pkg::AVG_DEPTH - 1));

    assign rpm_first  = out_first_reg;
    assign rpm_second = out_second_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= ftrpm_pkg::TIMEOUT_RESET;
            numer_reg   <= ftrpm_pkg::NUMERATOR_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                ftrpm_pkg::CFG_STOP_TIMEOUT: begin
                    timeout_reg <= cfg_data[ftrpm_pkg::TIMEOUT_W-1:0];
                end
                ftrpm_pkg::CFG_RPM_NUMERATOR: begin
                    numer_reg <= cfg_data[ftrpm_pkg::RPM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg <= ftrpm_pkg::action_t'(action);
            ch_reg  <= channel;
            cap_reg <= capture_value;
            now_reg <= now_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovf_reg <= '0;
            for (int c = 0; c < ftrpm_pkg::NUM_CHANNELS; c++) begin
                last_stamp_reg[c] <= '0;
                last_pulse_reg[c] <= '0;
            end
        end else if (cmd.exec) begin
            if (act_reg == ftrpm_pkg::ACT_OVERFLOW) begin
                ovf_reg <= ovf_reg + 1'b1;
            end
            if (sts.is_capture) begin
                last_stamp_reg[ch_reg] <= stamp;
                last_pulse_reg[ch_reg] <= now_reg;
            end
        end
    end

    // history is always read below the fill mark, so it needs no reset
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            hist_reg[ch_reg][slot_reg[ch_reg]] <= rpm_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < ftrpm_pkg::NUM_CHANNELS; c++) begin
                fill_reg[c] <= '0;
                slot_reg[c] <= '0;
            end
        end else if (cmd.push) begin
            if (slot_reg[ch_reg] == ftrpm_pkg::SLOT_W'(ftrpm_pkg::AVG_DEPTH - 1)) begin
                slot_reg[ch_reg] <= '0;
            end else begin
                slot_reg[ch_reg] <= slot_reg[ch_reg] + 1'b1;
            end
            if (fill_reg[ch_reg] < ftrpm_pkg::FILL_W'(ftrpm_pkg::AVG_DEPTH)) begin
                fill_reg[ch_reg] <= fill_reg[ch_reg] + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            acc_reg <= '0;
            k_reg   <= '0;
        end else if (cmd.sum_step) begin
            if (ftrpm_pkg::FILL_W'(k_reg) < fill_reg[ch_reg]) begin
                acc_reg <= acc_reg + ftrpm_pkg::SUM_W'(hist_reg[ch_reg][k_reg]);
            end
            k_reg <= k_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < ftrpm_pkg::NUM_CHANNELS; c++) begin
                avg_reg[c] <= '0;
            end
        end else if (cmd.exec && (act_reg == ftrpm_pkg::ACT_SERVICE)) begin
            for (int c = 0; c < ftrpm_pkg::NUM_CHANNELS; c++) begin
                if ((now_reg - last_pulse_reg[c]) > ftrpm_pkg::TIME_W'(timeout_reg)) begin
                    avg_reg[c] <= '0;
                end
            end
        end else if (cmd.avg_write) begin
            avg_reg[ch_reg] <= dvd_reg[ftrpm_pkg::RPM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.div_start) begin
            cnt_reg <= ftrpm_pkg::CNT_W'(ftrpm_pkg::DIV_W);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            rem_reg <= '0;
            if (cmd.div_sel_avg) begin
                dvd_reg <= acc_reg;
                dvs_reg <= ftrpm_pkg::DIVS_W'(fill_reg[ch_reg]);
            end else begin
                dvd_reg <= ftrpm_pkg::DIV_W'(numer_reg);
                dvs_reg <= diff;
            end
        end else if (cnt_reg != '0) begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_first_reg <= avg_reg[0];
            if (ftrpm_pkg::NUM_CHANNELS > 1) begin
                out_second_reg <= avg_reg[ftrpm_pkg::CH_SECOND];
            end else begin
                out_second_reg <= '0;
            end
        end
    end

    `ASSERT_PROP(a_div_start_idle, aclk, aresetn, cmd.div_start |-> cnt_reg == '0)
    `ASSERT_PROP(a_fill_after_push, aclk, aresetn, cmd.push |=> fill_reg[ch_reg] != '0)

endmodule

`default_nettype wire

### src/ftrpm_ctrl.sv
// ----------------------------------------------------------------------------
// ftrpm_ctrl
// Sequencer of the tachometer: one word at a time, output register handoff.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ftrpm_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    input  wire ftrpm_pkg::sts_t  sts,
    output ftrpm_pkg::cmd_t       cmd
);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_EXEC   = 9'b000000010,
        ST_DIV1   = 9'b000000100,
        ST_PUSH   = 9'b000001000,
        ST_SUM    = 9'b000010000,
        ST_START2 = 9'b000100000,
        ST_DIV2   = 9'b001000000,
        ST_AVGWR  = 9'b010000000,
        ST_OUT    = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                if (sts.is_capture) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV1;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV1: begin
                if (sts.div_done) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                cmd.push   = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum_step = 1'b1;
                if (sts.sum_last) begin
                    state_next = ST_START2;
                end
            end
            ST_START2: begin
                cmd.div_start   = 1'b1;
                cmd.div_sel_avg = 1'b1;
                state_next      = ST_DIV2;
            end
            ST_DIV2: begin
                if (sts.div_done) begin
                    state_next = ST_AVGWR;
                end
            end
            ST_AVGWR: begin
                cmd.avg_write = 1'b1;
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                // wait until the output register is free or being drained
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    `ASSERT_NEVER(a_no_overwrite, aclk, aresetn, cmd.out_load && m_tvalid_reg && !m_tready)
    `ASSERT_PROP(a_accept_to_exec, aclk, aresetn, (s_tvalid && s_tready) |=> state_reg == ST_EXEC)
    `ASSERT_NEVER(a_done_outside_wait, aclk, aresetn, sts.div_done && !(state_reg == ST_DIV1 || state_reg == ST_DIV2))

endmodule

`default_nettype wire

### src/fan_tach_rpm_meter.sv
// ----------------------------------------------------------------------------
// fan_tach_rpm_meter
// Two-channel fan tachometer with a four-deep moving average of rpm.
//
// Every input word gives exactly one output word holding both channel
// averages. Words are taken one at a time; the output register lets a new
// word in while the previous result still waits. A timer overflow, a stall
// service check or a no-op passes through the execute and output states
// only. An edge capture runs the shared radix-2 divider twice, one quotient
// bit per cycle (period to rpm, then sum to average), plus a pass over the
// history. In both cases the result becomes valid in the same cycle as the
// input is ready again. A result held by output back-pressure delays the
// next result only when it is ready to leave. The configuration port accepts
// a write in every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fan_tach_rpm_meter (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // tdata: capture_value [15:0], now_ms [47:16]
    input  wire logic [ftrpm_pkg::IN_TDATA_W-1:0]       s_tdata,
    // tuser: action [1:0], channel [2]
    input  wire logic [ftrpm_pkg::IN_TUSER_W-1:0]       s_tuser,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // tdata: rpm_first [25:0], rpm_second [51:26], zero [55:52]
    output logic      [ftrpm_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [ftrpm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [ftrpm_pkg::CFG_DATA_W-1:0]       cfg_data
);

    ftrpm_pkg::cmd_t cmd;
    ftrpm_pkg::sts_t sts;

    logic [ftrpm_pkg::RPM_W-1:0] rpm_first;
    logic [ftrpm_pkg::RPM_W-1:0] rpm_second;

    assign cfg_ready = 1'b1;
    assign m_tdata   = ftrpm_pkg::OUT_TDATA_W'({rpm_second, rpm_first});

    ftrpm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ftrpm_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .action        (s_tuser[ftrpm_pkg::ACT_W-1:0]),
        .channel       (s_tuser[ftrpm_pkg::ACT_W +: ftrpm_pkg::CH_W]),
        .capture_value (s_tdata[ftrpm_pkg::CAP_W-1:0]),
        .now_ms        (s_tdata[ftrpm_pkg::CAP_W +: ftrpm_pkg::TIME_W]),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .rpm_first     (rpm_first),
        .rpm_second    (rpm_second)
    );

endmodule

`default_nettype wire

### dv/ftrpm_checker.sv
// ----------------------------------------------------------------------------
// ftrpm_checker
// Watches the input, result and register channels of the rpm meter, keeps
// its own copy of the tachometer state, predicts the two channel averages
// for every accepted input word and compares them with the result words.
// ----------------------------------------------------------------------------
`default_nettype none

module ftrpm_checker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic [ftrpm_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  wire logic [ftrpm_pkg::IN_TUSER_W-1:0]  s_tuser,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tready,
    input  wire logic [ftrpm_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic                              cfg_valid,
    input  wire logic                              cfg_ready,
    input  wire logic [ftrpm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ftrpm_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                                     pending_words,
    output int                                     fail_count
);

    typedef struct {
        logic [ftrpm_pkg::RPM_W-1:0] first;
        logic [ftrpm_pkg::RPM_W-1:0] second;
    } rpm_pair_t;

    logic [ftrpm_pkg::TIMEOUT_W-1:0] timeout_ms;
    logic [ftrpm_pkg::RPM_W-1:0]     numerator;
    logic [ftrpm_pkg::OVF_W-1:0]     ovf_count;
    logic [ftrpm_pkg::STAMP_W-1:0]   prev_stamp [ftrpm_pkg::NUM_CHANNELS];
    logic [ftrpm_pkg::TIME_W-1:0]    pulse_ms   [ftrpm_pkg::NUM_CHANNELS];
    logic [ftrpm_pkg::RPM_W-1:0]
        ring [ftrpm_pkg::NUM_CHANNELS][ftrpm_pkg::AVG_DEPTH];
    int                              ring_fill  [ftrpm_pkg::NUM_CHANNELS];
    int                              ring_slot  [ftrpm_pkg::NUM_CHANNELS];
    logic [ftrpm_pkg::RPM_W-1:0]     avg_rpm    [ftrpm_pkg::NUM_CHANNELS];

    rpm_pair_t expected_rpm [$];
    int        mismatches = 0;

    initial begin
        pending_words = 0;
        fail_count    = 0;
    end

    function automatic void clear_meter();
        timeout_ms = ftrpm_pkg::TIMEOUT_RESET;
        numerator  = ftrpm_pkg::NUMERATOR_RESET;
        ovf_count  = '0;
        for (int c = 0; c < ftrpm_pkg::NUM_CHANNELS; c++) begin
            prev_stamp[c] = '0;
            pulse_ms[c]   = '0;
            ring_fill[c]  = 0;
            ring_slot[c]  = 0;
            avg_rpm[c]    = '0;
            for (int k = 0; k < ftrpm_pkg::AVG_DEPTH; k++) begin
                ring[c][k] = '0;
            end
        end
    endfunction

    // applies one input word to the state and returns both averages after it
    function automatic rpm_pair_t advance_meter(ftrpm_pkg::action_t act, logic ch,
                                                logic [ftrpm_pkg::CAP_W-1:0] cap,
                                                logic [ftrpm_pkg::TIME_W-1:0] now);
        logic [ftrpm_pkg::STAMP_W-1:0] stamp;
        logic [ftrpm_pkg::STAMP_W-1:0] diff;
        logic [31:0]                   sum;
        logic [ftrpm_pkg::RPM_W-1:0]   rate;
        int                            c;
        rpm_pair_t                     pair;
        c = int'(ch);
        case (act)
            ftrpm_pkg::ACT_OVERFLOW: begin
                ovf_count = ovf_count + 1'b1;
            end
            ftrpm_pkg::ACT_CAPTURE: begin
                if (c < ftrpm_pkg::NUM_CHANNELS) begin
                    stamp         = {ovf_count, cap};
                    diff          = stamp - prev_stamp[c];
                    prev_stamp[c] = stamp;
                    pulse_ms[c]   = now;
                    rate          = (diff == 0) ? '0 :
                                    ftrpm_pkg::RPM_W'(32'(numerator) / diff);
                    ring[c][ring_slot[c]] = rate;
                    ring_slot[c] = (ring_slot[c] + 1) % ftrpm_pkg::AVG_DEPTH;
                    if (ring_fill[c] < ftrpm_pkg::AVG_DEPTH) begin
                        ring_fill[c]++;
                    end
                    sum = '0;
                    for (int k = 0; k < ring_fill[c]; k++) begin
                        sum += 32'(ring[c][k]);
                    end
                    avg_rpm[c] = ftrpm_pkg::RPM_W'(sum / 32'(ring_fill[c]));
                end
            end
            ftrpm_pkg::ACT_SERVICE: begin
                for (int k = 0; k < ftrpm_pkg::NUM_CHANNELS; k++) begin
                    if (ftrpm_pkg::TIME_W'(now - pulse_ms[k]) >
                        ftrpm_pkg::TIME_W'(timeout_ms)) begin
                        avg_rpm[k] = '0;
                    end
                end
            end
            default: ;
        endcase
        pair.first  = avg_rpm[0];
        pair.second = (ftrpm_pkg::NUM_CHANNELS > 1) ? avg_rpm[ftrpm_pkg::CH_SECOND] : '0;
        return pair;
    endfunction

    always @(posedge aclk) begin
        rpm_pair_t want;
        if (!aresetn) begin
            clear_meter();
            expected_rpm.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_rpm.size() == 0) begin
                    $error("result word with nothing expected: %h", m_tdata);
                    mismatches++;
                end else begin
                    want = expected_rpm.pop_front();
                    if (m_tdata[ftrpm_pkg::RPM_W-1:0] !== want.first) begin
                        $error("rpm_first: expected %0d, actual %0d",
                               want.first, m_tdata[ftrpm_pkg::RPM_W-1:0]);
                        mismatches++;
                    end
                    if (m_tdata[2*ftrpm_pkg::RPM_W-1:ftrpm_pkg::RPM_W] !== want.second) begin
                        $error("rpm_second: expected %0d, actual %0d",
                               want.second, m_tdata[2*ftrpm_pkg::RPM_W-1:ftrpm_pkg::RPM_W]);
                        mismatches++;
                    end
                    if (m_tdata[ftrpm_pkg::OUT_TDATA_W-1:2*ftrpm_pkg::RPM_W] !== '0) begin
                        $error("pad: expected 0, actual %0d",
                               m_tdata[ftrpm_pkg::OUT_TDATA_W-1:2*ftrpm_pkg::RPM_W]);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    ftrpm_pkg::CFG_STOP_TIMEOUT:
                        timeout_ms = cfg_data[ftrpm_pkg::TIMEOUT_W-1:0];
                    ftrpm_pkg::CFG_RPM_NUMERATOR:
                        numerator  = cfg_data[ftrpm_pkg::RPM_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                expected_rpm.push_back(advance_meter(
                    ftrpm_pkg::action_t'(s_tuser[ftrpm_pkg::ACT_W-1:0]),
                    s_tuser[ftrpm_pkg::ACT_W],
                    s_tdata[ftrpm_pkg::CAP_W-1:0],
                    s_tdata[ftrpm_pkg::CAP_W+ftrpm_pkg::TIME_W-1:ftrpm_pkg::CAP_W]));
            end
        end
        pending_words <= expected_rpm.size();
        fail_count    <= mismatches;
    end

endmodule

`default_nettype wire

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the fan tachometer rpm meter: directed edge cases, a short
// walk of the overflow count, then random fan-like capture sequences
// mixed with noise under several register settings and random idling.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int TAIL_CYCLES = 80;
    localparam int PHASE_WORDS = 220;

    logic                              aclk      = 1'b0;
    logic                              aresetn   = 1'b0;
    logic [ftrpm_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [ftrpm_pkg::IN_TUSER_W-1:0]  s_tuser   = '0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    logic [ftrpm_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [ftrpm_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [ftrpm_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    int   pending_words;
    int   fail_count;
    logic quiet       = 1'b0;
    int   stall_left  = 0;
    int   words_sent  = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    fan_tach_rpm_meter u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ftrpm_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .m_tdata       (m_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pending_words (pending_words),
        .fail_count    (fail_count)
    );

    // result side back-pressure in random bursts
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 14);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_word(ftrpm_pkg::action_t act, logic ch,
                             logic [ftrpm_pkg::CAP_W-1:0] cap,
                             logic [ftrpm_pkg::TIME_W-1:0] now);
        s_tdata  <= {now, cap};
        s_tuser  <= {ch, act};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
    endtask

    task automatic set_config(logic [ftrpm_pkg::TIMEOUT_W-1:0] timeout,
                              logic [ftrpm_pkg::RPM_W-1:0] num);
        cfg_index <= ftrpm_pkg::CFG_STOP_TIMEOUT;
        cfg_data  <= ftrpm_pkg::CFG_DATA_W'(timeout);
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_index <= ftrpm_pkg::CFG_RPM_NUMERATOR;
        cfg_data  <= num;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // every word gives a result, so an empty queue means the block is idle
    task automatic drain(int tail);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_words != 0) @(posedge aclk);
        repeat (tail) @(posedge aclk);
    endtask

    initial begin
        logic [ftrpm_pkg::TIMEOUT_W-1:0] tmo_set [5];
        logic [ftrpm_pkg::RPM_W-1:0]     num_set [5];
        logic [31:0]                     tick;
        logic [31:0]                     ms_now;
        logic [15:0]                     hi_prev;
        int                              target;
        int                              lo;
        int                              hi;
        int                              burst;

        tmo_set = '{16'hFFFF, 16'd1, 16'd0, 16'($urandom_range(1, 65535)),
                    ftrpm_pkg::TIMEOUT_RESET};
        num_set = '{26'h3FFFFFF, 26'd1, 26'd0, 26'($urandom_range(1, 60000000)),
                    ftrpm_pkg::NUMERATOR_RESET};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // first captures take the zero timestamp left by reset
        send_word(ftrpm_pkg::ACT_CAPTURE, 1'b0, 16'h0000, 32'd0);
        send_word(ftrpm_pkg::ACT_CAPTURE, 1'b1, 16'hFFFF, 32'hFFFFFFFF);
        send_word(ftrpm_pkg::ACT_NOP, 1'b1, 16'hA5A5, 32'h5A5A5A5A);
        send_word(ftrpm_pkg::ACT_OVERFLOW, 1'b0, 16'h5A5A, 32'hA5A5A5A5);
        send_word(ftrpm_pkg::ACT_CAPTURE, 1'b0, 16'h8000, 32'd10);
        send_word(ftrpm_pkg::ACT_CAPTURE, 1'b0, 16'h8000, 32'd15);
        send_word(ftrpm_pkg::ACT_CAPTURE, 1'b0, 16'h8100, 32'd20);
        send_word(ftrpm_pkg::ACT_CAPTURE, 1'b0, 16'h8200, 32'd30);
        send_word(ftrpm_pkg::ACT_CAPTURE, 1'b0, 16'h8300, 32'd40);
        // elapsed exactly at the timeout keeps channel 0, channel 1 stalls
        send_word(ftrpm_pkg::ACT_SERVICE, 1'b0, 16'h0000, 32'd1040);
        send_word(ftrpm_pkg::ACT_SERVICE, 1'b1, 16'hFFFF, 32'd1041);
        send_word(ftrpm_pkg::ACT_CAPTURE, 1'b1, 16'h0010, 32'd2000);
        send_word(ftrpm_pkg::ACT_CAPTURE, 1'b0, 16'h0000, 32'd2000);
        drain(4);
        set_config(16'd0, 26'h3FFFFFF);
        send_word(ftrpm_pkg::ACT_OVERFLOW, 1'b1, 16'hFFFF, 32'hFFFFFFFF);
        send_word(ftrpm_pkg::ACT_CAPTURE, 1'b0, 16'h0001, 32'd5000);
        send_word(ftrpm_pkg::ACT_CAPTURE, 1'b0, 16'h0002, 32'd5000);
        send_word(ftrpm_pkg::ACT_SERVICE, 1'b0, 16'h0000, 32'd5000);
        send_word(ftrpm_pkg::ACT_SERVICE, 1'b0, 16'h0000, 32'd5001);
        send_word(ftrpm_pkg::ACT_CAPTURE, 1'b1, 16'h7FFF, 32'h80000000);
        send_word(ftrpm_pkg::ACT_NOP, 1'b0, 16'h0000, 32'd0);

        // walk the overflow count with captures along the way
        quiet <= 1'b1;
        for (int i = 0; i < 64; i++) begin
            send_word(ftrpm_pkg::ACT_OVERFLOW, 1'($urandom), 16'($urandom), $urandom);
            if (i % 16 == 15) begin
                send_word(ftrpm_pkg::ACT_CAPTURE, i[4], 16'($urandom), $urandom);
            end
        end
        quiet <= 1'b0;

        for (int p = 0; p < 5; p++) begin
            drain(4);
            set_config(tmo_set[p], num_set[p]);
            if (p == 4) begin
                quiet <= 1'b1;
            end
            ms_now = $urandom;
            tick   = $urandom;
            target = words_sent + PHASE_WORDS;
            while (words_sent < target) begin
                if ($urandom_range(0, 9) < 7) begin
                    // fan-like run: overflows as the timer rolls, captures at its low half
                    case ($urandom_range(0, 3))
                        0: begin lo = 1;     hi = 200;    end
                        1: begin lo = 200;   hi = 20000;  end
                        2: begin lo = 20000; hi = 200000; end
                        default: begin lo = 0; hi = 70000; end
                    endcase
                    burst = $urandom_range(8, 40);
                    for (int e = 0; e < burst; e++) begin
                        if ($urandom_range(0, 9) == 0) begin
                            send_word(ftrpm_pkg::ACT_SERVICE, 1'($urandom), 16'($urandom),
                                      ms_now + (($urandom_range(0, 3) == 0) ?
                                      $urandom_range(0, 70000) : $urandom_range(0, 3)));
                        end else begin
                            hi_prev = tick[31:16];
                            tick    = tick + $urandom_range(lo, hi);
                            repeat (16'(tick[31:16] - hi_prev)) begin
                                send_word(ftrpm_pkg::ACT_OVERFLOW, 1'b0, 16'h0000, ms_now);
                            end
                            ms_now = ms_now + $urandom_range(0, 50);
                            send_word(ftrpm_pkg::ACT_CAPTURE, 1'($urandom), tick[15:0],
                                      ms_now);
                        end
                    end
                end else begin
                    repeat ($urandom_range(1, 10)) begin
                        send_word(ftrpm_pkg::action_t'($urandom_range(0, 3)), 1'($urandom),
                                  16'($urandom), $urandom);
                    end
                end
            end
        end

        drain(TAIL_CYCLES);
        if (fail_count == 0 && pending_words == 0) begin
            $display("[fan_tach_rpm_meter] OK");
        end else begin
            $display("[fan_tach_rpm_meter] ERROR");
        end
        $finish;
    end

    initial begin
        for (int n = 0; n < CYCLE_LIMIT; n++) begin
            @(posedge aclk);
        end
        $display("[fan_tach_rpm_meter] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
+incdir+src
src/ftrpm_pkg.sv
src/ftrpm_dp.sv
src/ftrpm_ctrl.sv
src/fan_tach_rpm_meter.sv
dv/ftrpm_checker.sv
dv/tb_top.sv
